FILE: hw/rtl/pca_pkg.sv
// ----------------------------------------------------------------------------
// pca_pkg: shared types and constants for the polygon area/centroid block
// Field widths, accumulator widths, the queue entry and the winding codes.
// ----------------------------------------------------------------------------
package pca_pkg;

  // Accumulator widths (wrapping two's complement)
  localparam int AREA_W = 48;
  localparam int MOM_W  = 64;

  // Result field widths
  localparam int AREA_OUT_W = 34;
  localparam int CENT_W     = 24;
  localparam int WIND_W     = 2;
  localparam int CNT_W      = 12;

  // Vertex count saturates here
  localparam logic [CNT_W-1:0] CNT_MAX = 12'hFFF;

  // Centroid saturation magnitudes
  localparam logic [CENT_W-1:0] CENT_POS_MAX = 24'h7F_FFFF;
  localparam logic [CENT_W-1:0] CENT_NEG_MAG = 24'h80_0000;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [WIND_W-1:0] {
    WIND_NONE = 2'd0,
    WIND_CCW  = 2'd1,
    WIND_CW   = 2'd2
  } pca_wind_e;

  // One closed polygon's sums, handed from front to back
  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic [MOM_W-1:0]  mom_x;
    logic [MOM_W-1:0]  mom_y;
    logic [CNT_W-1:0]  count;
  } pca_entry_t;

endpackage

FILE: hw/rtl/pca_if.sv
// ----------------------------------------------------------------------------
// pca_if: valid/ready channels of the polygon area/centroid block
// Vertex channel in, result channel out.
// ----------------------------------------------------------------------------
interface pca_vertex_if #(
  parameter int CoordBits = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] vertex_x;
  logic signed [CoordBits-1:0] vertex_y;
  logic                        last_vertex;

  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface pca_result_if;
  import pca_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [AREA_OUT_W-1:0]    doubled_area;
  logic signed [CENT_W-1:0] centroid_x;
  logic signed [CENT_W-1:0] centroid_y;
  logic [WIND_W-1:0]        winding;
  logic [CNT_W-1:0]         vertex_total;

  modport source (output valid, doubled_area, centroid_x, centroid_y, winding,
                  vertex_total, input ready);
  modport sink   (input valid, doubled_area, centroid_x, centroid_y, winding,
                  vertex_total, output ready);
endinterface

FILE: hw/rtl/pca_front.sv
// ----------------------------------------------------------------------------
// pca_front: vertex intake and shoelace accumulation
// Takes vertices, runs each edge through multiply / subtract / moment
// multiply / accumulate, closes the polygon and pushes its sums to the queue.
// ----------------------------------------------------------------------------
module pca_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  pca_vertex_if.sink          vtx_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output pca_pkg::pca_entry_t push_entry_o
);
  import pca_pkg::*;

  localparam int CB      = COORD_BITS;
  localparam int PROD_W  = 2 * CB;
  localparam int CROSS_W = 2 * CB + 1;
  localparam int SUM_W   = CB + 1;
  localparam int MOMP_W  = 3 * CB + 2;

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_MUL  = 6'b000010,
    F_DIFF = 6'b000100,
    F_MOM  = 6'b001000,
    F_ACC  = 6'b010000,
    F_PUSH = 6'b100000
  } front_state_e;

  front_state_e state_q;

  logic signed [CB-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic [AREA_W-1:0]    area_q;
  logic [MOM_W-1:0]     mom_x_q, mom_y_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [CNT_W-1:0]     cnt_inc;
  logic                 last_q;
  logic                 closing_q;
  logic                 accept;

  // edge datapath (no reset)
  logic signed [CB-1:0]      epx_q, epy_q, eqx_q, eqy_q;
  logic signed [PROD_W-1:0]  p1_q, p2_q;
  logic signed [SUM_W-1:0]   sx_q, sy_q;
  logic signed [CROSS_W-1:0] a_q;
  logic signed [MOMP_W-1:0]  pmx_q, pmy_q;

  assign vtx_i.ready  = (state_q == F_IDLE);
  assign accept       = vtx_i.valid && vtx_i.ready;
  assign cnt_inc      = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 12'd1;

  assign push_valid_o       = (state_q == F_PUSH);
  assign push_entry_o.area  = area_q;
  assign push_entry_o.mom_x = mom_x_q;
  assign push_entry_o.mom_y = mom_y_q;
  assign push_entry_o.count = cnt_q;

  // sequencer and polygon state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      area_q    <= '0;
      mom_x_q   <= '0;
      mom_y_q   <= '0;
      cnt_q     <= '0;
      last_q    <= 1'b0;
      closing_q <= 1'b0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (accept) begin
            last_q    <= vtx_i.last_vertex;
            closing_q <= 1'b0;
            prev_x_q  <= vtx_i.vertex_x;
            prev_y_q  <= vtx_i.vertex_y;
            cnt_q     <= cnt_inc;
            if (cnt_q == '0) begin
              // first vertex opens a polygon; a lone vertex closes at once
              first_x_q <= vtx_i.vertex_x;
              first_y_q <= vtx_i.vertex_y;
              area_q    <= '0;
              mom_x_q   <= '0;
              mom_y_q   <= '0;
              if (vtx_i.last_vertex) state_q <= F_PUSH;
            end else begin
              state_q <= F_MUL;
            end
          end
        end
        F_MUL:  state_q <= F_DIFF;
        F_DIFF: state_q <= F_MOM;
        F_MOM: begin
          area_q  <= area_q + AREA_W'(a_q);
          state_q <= F_ACC;
        end
        F_ACC: begin
          mom_x_q <= mom_x_q + MOM_W'(pmx_q);
          mom_y_q <= mom_y_q + MOM_W'(pmy_q);
          if (last_q && !closing_q) begin
            closing_q <= 1'b1;
            state_q   <= F_MUL;
          end else if (last_q) begin
            state_q <= F_PUSH;
          end else begin
            state_q <= F_IDLE;
          end
        end
        F_PUSH: begin
          if (push_ready_i) begin
            cnt_q   <= '0;
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  // edge arithmetic, one stage per state
  always_ff @(posedge clk_i) begin
    if (accept) begin
      epx_q <= prev_x_q;
      epy_q <= prev_y_q;
      eqx_q <= vtx_i.vertex_x;
      eqy_q <= vtx_i.vertex_y;
    end else if (state_q == F_ACC) begin
      // closing edge: last vertex back to the first
      epx_q <= prev_x_q;
      epy_q <= prev_y_q;
      eqx_q <= first_x_q;
      eqy_q <= first_y_q;
    end
    if (state_q == F_MUL) begin
      p1_q <= epx_q * eqy_q;
      p2_q <= eqx_q * epy_q;
      sx_q <= epx_q + eqx_q;
      sy_q <= epy_q + eqy_q;
    end
    if (state_q == F_DIFF) begin
      a_q <= p1_q - p2_q;
    end
    if (state_q == F_MOM) begin
      pmx_q <= sx_q * a_q;
      pmy_q <= sy_q * a_q;
    end
  end

endmodule

FILE: hw/rtl/pca_queue.sv
// ----------------------------------------------------------------------------
// pca_queue: short queue of closed-polygon sums
// Lets the vertex front and the divide back stall independently.
// ----------------------------------------------------------------------------
module pca_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  pca_pkg::pca_entry_t push_entry_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output pca_pkg::pca_entry_t pop_entry_o
);
  import pca_pkg::*;

  pca_entry_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_entry_i;
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/pca_back.sv
// ----------------------------------------------------------------------------
// pca_back: area magnitude, centroid division and result register
// Takes one polygon's sums, divides both moments by 3*|2A| one quotient bit
// per cycle, saturates and holds the result until it is taken.
// ----------------------------------------------------------------------------
module pca_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  pca_pkg::pca_entry_t pop_entry_i,
  pca_result_if.source        res_o
);
  import pca_pkg::*;

  localparam int NUM_W  = MOM_W + FRAC_BITS;
  localparam int DIV_W  = AREA_W + 2;
  localparam int STEP_W = $clog2(NUM_W);

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_PREP  = 4'b0010,
    B_DIV   = 4'b0100,
    B_WRITE = 4'b1000
  } back_state_e;

  back_state_e state_q;
  logic [STEP_W-1:0] step_q;

  // operands (no reset)
  logic [AREA_W-1:0] mag_q;
  logic [DIV_W-1:0]  d_q;
  logic              zero_q, aneg_q, negx_q, negy_q;
  logic [NUM_W-1:0]  numx_q, numy_q, qx_q, qy_q;
  logic [DIV_W-1:0]  remx_q, remy_q;
  logic [CNT_W-1:0]  cnt_q;

  // result register
  logic                     res_valid_q;
  logic [AREA_OUT_W-1:0]    res_area_q;
  logic [CENT_W-1:0]        res_cx_q, res_cy_q;
  logic [WIND_W-1:0]        res_wind_q;
  logic [CNT_W-1:0]         res_cnt_q;

  logic              pop, load;
  logic [MOM_W-1:0]  absmx, absmy;
  logic [DIV_W:0]    trialx, trialy;
  logic              qbitx, qbity;
  logic [NUM_W-1:0]  limx, limy;
  logic [CENT_W-1:0] satx, saty, centx, centy;
  logic [AREA_OUT_W-1:0] area_sat;

  assign pop_ready_o = (state_q == B_IDLE);
  assign pop         = pop_valid_i && pop_ready_o;
  assign load        = (state_q == B_WRITE) && (!res_valid_q || res_o.ready);

  assign absmx = pop_entry_i.mom_x[MOM_W-1] ? (~pop_entry_i.mom_x + 1'b1) : pop_entry_i.mom_x;
  assign absmy = pop_entry_i.mom_y[MOM_W-1] ? (~pop_entry_i.mom_y + 1'b1) : pop_entry_i.mom_y;

  // one restoring-division step for each moment
  always_comb begin
    trialx = {remx_q, numx_q[NUM_W-1]};
    trialy = {remy_q, numy_q[NUM_W-1]};
    qbitx  = (trialx >= {1'b0, d_q});
    qbity  = (trialy >= {1'b0, d_q});
  end

  // saturate and apply sign
  always_comb begin
    limx     = negx_q ? NUM_W'(CENT_NEG_MAG) : NUM_W'(CENT_POS_MAX);
    limy     = negy_q ? NUM_W'(CENT_NEG_MAG) : NUM_W'(CENT_POS_MAX);
    satx     = (qx_q > limx) ? limx[CENT_W-1:0] : qx_q[CENT_W-1:0];
    saty     = (qy_q > limy) ? limy[CENT_W-1:0] : qy_q[CENT_W-1:0];
    centx    = negx_q ? (~satx + 1'b1) : satx;
    centy    = negy_q ? (~saty + 1'b1) : saty;
    area_sat = (|mag_q[AREA_W-1:AREA_OUT_W]) ? '1 : mag_q[AREA_OUT_W-1:0];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        B_IDLE: if (pop) state_q <= B_PREP;
        B_PREP: begin
          step_q  <= STEP_W'(NUM_W - 1);
          state_q <= zero_q ? B_WRITE : B_DIV;
        end
        B_DIV: begin
          if (step_q == '0) state_q <= B_WRITE;
          else step_q <= step_q - 1'b1;
        end
        B_WRITE: if (load) state_q <= B_IDLE;
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    if (pop) begin
      mag_q  <= pop_entry_i.area[AREA_W-1] ? (~pop_entry_i.area + 1'b1) : pop_entry_i.area;
      zero_q <= (pop_entry_i.area == '0);
      aneg_q <= pop_entry_i.area[AREA_W-1];
      negx_q <= pop_entry_i.mom_x[MOM_W-1] ^ pop_entry_i.area[AREA_W-1];
      negy_q <= pop_entry_i.mom_y[MOM_W-1] ^ pop_entry_i.area[AREA_W-1];
      numx_q <= NUM_W'(absmx) << FRAC_BITS;
      numy_q <= NUM_W'(absmy) << FRAC_BITS;
      remx_q <= '0;
      remy_q <= '0;
      qx_q   <= '0;
      qy_q   <= '0;
      cnt_q  <= pop_entry_i.count;
    end
    if (state_q == B_PREP) begin
      // divisor is 3 * |2A|
      d_q <= {1'b0, mag_q, 1'b0} + DIV_W'(mag_q);
    end
    if (state_q == B_DIV) begin
      numx_q <= numx_q << 1;
      numy_q <= numy_q << 1;
      remx_q <= qbitx ? DIV_W'(trialx - {1'b0, d_q}) : trialx[DIV_W-1:0];
      remy_q <= qbity ? DIV_W'(trialy - {1'b0, d_q}) : trialy[DIV_W-1:0];
      qx_q   <= {qx_q[NUM_W-2:0], qbitx};
      qy_q   <= {qy_q[NUM_W-2:0], qbity};
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_area_q <= area_sat;
      res_cnt_q  <= cnt_q;
      if (zero_q) begin
        res_cx_q   <= '0;
        res_cy_q   <= '0;
        res_wind_q <= WIND_NONE;
      end else begin
        res_cx_q   <= centx;
        res_cy_q   <= centy;
        res_wind_q <= aneg_q ? WIND_CW : WIND_CCW;
      end
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.doubled_area = res_area_q;
  assign res_o.centroid_x   = res_cx_q;
  assign res_o.centroid_y   = res_cy_q;
  assign res_o.winding      = res_wind_q;
  assign res_o.vertex_total = res_cnt_q;

endmodule

FILE: hw/rtl/polygon_centroid_area.sv
// Polygon doubled area and centroid (shoelace). Vertices come in one per
// transfer; each vertex after the first passes through the front's steps
// (intake, cross-product multiply, subtract, moment multiply, accumulate),
// a last vertex runs the closing edge through the steps after intake and
// then hands its sums to a two-entry queue. The back divides both moments
// by 3*|2A| one quotient bit per cycle (pop, divisor, 64+FRAC_BITS steps,
// write), skipping the division steps for a zero-area polygon; it overlaps the next
// polygon's vertices, so polygons shorter than about fifteen vertices are
// paced by the divider. Results are held in an output register until taken.
// ----------------------------------------------------------------------------
// polygon_centroid_area: top level
// Front accumulator, sums queue and centroid divider.
// ----------------------------------------------------------------------------
module polygon_centroid_area #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pca_vertex_if.sink   vtx_i,
  pca_result_if.source res_o
);
  import pca_pkg::*;

  logic       q_push_valid, q_push_ready;
  logic       q_pop_valid, q_pop_ready;
  pca_entry_t q_push_entry, q_pop_entry;

  pca_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vtx_i       (vtx_i),
    .push_valid_o(q_push_valid),
    .push_ready_i(q_push_ready),
    .push_entry_o(q_push_entry)
  );

  pca_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(q_push_valid),
    .push_ready_o(q_push_ready),
    .push_entry_i(q_push_entry),
    .pop_valid_o (q_pop_valid),
    .pop_ready_i (q_pop_ready),
    .pop_entry_o (q_pop_entry)
  );

  pca_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(q_pop_valid),
    .pop_ready_o(q_pop_ready),
    .pop_entry_i(q_pop_entry),
    .res_o      (res_o)
  );

`ifndef SYNTHESIS
  // the front never hands sums to the queue while it takes a vertex
  a_no_push_on_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vtx_i.valid && vtx_i.ready) |-> !q_push_valid)
    else $error("queue push during vertex intake");

  // the back is not ready again in the cycle after taking an entry
  a_back_busy_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_valid && q_pop_ready) |=> !q_pop_ready)
    else $error("back took two entries back to back");

  // winding is degenerate exactly when the area is zero
  a_wind_matches_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> ((res_o.winding == WIND_NONE) == (res_o.doubled_area == '0)))
    else $error("winding disagrees with area");
`endif

endmodule
